FILE: hdl/btlbs_pkg.sv
package btlbs_pkg;

  localparam int MAX_ATOMS  = 65536;
  localparam int MAX_BLOCKS = 64;
  localparam int ATOM_AW    = $clog2(MAX_ATOMS);
  localparam int BLK_W      = $clog2(MAX_BLOCKS);
  localparam int FIELD_W    = 16;
  localparam int SITE_W     = 16;
  localparam int SITE_SHIFT = 16;
  localparam int PACK_W     = 32;
  localparam int LANES      = 8;
  localparam int SLOTS      = 3;
  localparam int TYPES      = 6;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int ENABLE_W   = 6;

  typedef logic [BLK_W-1:0]            blk_t;
  typedef logic [BLK_W:0]              cnt_t;
  typedef logic [LANES-1:0][BLK_W-1:0] blk_vec_t;

  localparam logic [FIELD_W:0] ATOM_LIM    = (FIELD_W+1)'(MAX_ATOMS);
  localparam logic [FIELD_W:0] BLK_LIM     = (FIELD_W+1)'(MAX_BLOCKS);
  localparam cnt_t             BLK_CNT_LIM = cnt_t'(MAX_BLOCKS);

  typedef enum logic [1:0] {
    MODE_QUERY,
    MODE_WR_ATOM,
    MODE_WR_SITE,
    MODE_NOP
  } mode_t;

  typedef enum logic [2:0] {
    TERM_BOND,
    TERM_UREY,
    TERM_ANGLE,
    TERM_DIHEDRAL,
    TERM_IMPROPER,
    TERM_CMAP
  } term_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_SITE_CLASH,
    STAT_TOO_MANY
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_COUNT,
    CFG_TERM_ENABLE
  } cfg_idx_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  typedef struct packed {
    mode_t                  mode;
    logic                   cmap;
    logic [FIELD_W-1:0]     waddr;
    logic [FIELD_W-1:0]     wval;
    logic [LANES-1:0]       lane_en;
    blk_vec_t               blk;
    blk_t                   m1;
    blk_t                   m2;
    blk_t                   m3;
    logic                   extra;
  } stage_t;

  function automatic logic [3:0] atoms_of(logic [2:0] t);
    logic [3:0] n;
    n = 4'd0;
    case (t) inside
      TERM_BOND:                   n = 4'd2;
      TERM_UREY, TERM_ANGLE:       n = 4'd3;
      TERM_DIHEDRAL, TERM_IMPROPER: n = 4'd4;
      TERM_CMAP:                   n = 4'd8;
      default:                     n = 4'd0;
    endcase
    return n;
  endfunction

  // largest lane value strictly below lim
  function automatic blk_t max_below(blk_vec_t v, cnt_t lim);
    blk_t best;
    best = '0;
    for (int j = 0; j < LANES; j++) begin
      if ({1'b0, v[j]} < lim && v[j] > best) begin
        best = v[j];
      end
    end
    return best;
  endfunction

endpackage

FILE: hdl/btlbs_if.sv
interface btlbs_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        mode;
  logic [2:0]                        term_type;
  logic [btlbs_pkg::FIELD_W-1:0]     atom_a;
  logic [btlbs_pkg::FIELD_W-1:0]     atom_b;
  logic [btlbs_pkg::FIELD_W-1:0]     atom_c;
  logic [btlbs_pkg::FIELD_W-1:0]     atom_d;
  logic [btlbs_pkg::FIELD_W-1:0]     atom_e;
  logic [btlbs_pkg::FIELD_W-1:0]     atom_f;
  logic [btlbs_pkg::FIELD_W-1:0]     atom_g;
  logic [btlbs_pkg::FIELD_W-1:0]     atom_h;
  logic [btlbs_pkg::FIELD_W-1:0]     write_address;
  logic [btlbs_pkg::FIELD_W-1:0]     write_value;

  modport source (
    output valid, mode, term_type, atom_a, atom_b, atom_c, atom_d,
           atom_e, atom_f, atom_g, atom_h, write_address, write_value,
    input  ready
  );
  modport sink (
    input  valid, mode, term_type, atom_a, atom_b, atom_c, atom_d,
           atom_e, atom_f, atom_g, atom_h, write_address, write_value,
    output ready
  );
endinterface

interface btlbs_out_if;
  logic                            valid;
  logic                            ready;
  logic [btlbs_pkg::PACK_W-1:0]    packed_first;
  logic [btlbs_pkg::PACK_W-1:0]    packed_second;
  logic [btlbs_pkg::PACK_W-1:0]    packed_third;
  logic [1:0]                      status;

  modport source (
    output valid, packed_first, packed_second, packed_third, status,
    input  ready
  );
  modport sink (
    input  valid, packed_first, packed_second, packed_third, status,
    output ready
  );
endinterface

FILE: hdl/btlbs_ram.sv
module btlbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/bonded_term_lambda_block_select_top.sv
// Lambda-block selection for bonded terms. One item (a term query, a table
// write or a no-op) is taken every cycle while no stage is stalled; its result is
// presented at the output and leaves in order, one per cycle, whenever the output side
// takes it. The atom-to-block table is held in eight copies so that all eight
// atom lookups of a term are made in the same cycle; the block-to-site table
// is held in three copies, one per result slot, read four stages on. After
// reset the atom table is cleared one entry a cycle, which keeps the input
// held off until all 65536 entries are cleared; configuration writes are taken throughout.
module bonded_term_lambda_block_select_top (
  input  logic                                clk,
  input  logic                                rst_n,
  btlbs_in_if.sink                            in_if,
  btlbs_out_if.source                         out_if,
  input  logic                                cfg_we,
  input  logic [btlbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [btlbs_pkg::CFG_W-1:0]         cfg_data
);

  // configuration
  btlbs_pkg::cnt_t                     block_count_r;
  logic [btlbs_pkg::ENABLE_W-1:0]      term_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= btlbs_pkg::cnt_t'(1);
      term_enable_r <= '1;
    end else if (cfg_we) begin
      unique case (btlbs_pkg::cfg_idx_t'(cfg_index))
        btlbs_pkg::CFG_BLOCK_COUNT: block_count_r <= cfg_data[btlbs_pkg::BLK_W:0];
        btlbs_pkg::CFG_TERM_ENABLE: term_enable_r <= cfg_data[btlbs_pkg::ENABLE_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing sequencer
  btlbs_pkg::state_t                   state_r, state_nxt;
  logic [btlbs_pkg::ATOM_AW-1:0]       clr_addr_r, clr_addr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= btlbs_pkg::ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    unique case (state_r)
      btlbs_pkg::ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          state_nxt = btlbs_pkg::ST_RUN;
        end
      end
      btlbs_pkg::ST_RUN: ;
      default: state_nxt = btlbs_pkg::ST_CLEAR;
    endcase
  end

  // pipeline control
  logic v1_r, v2_r, v3_r, v4_r, v5_r, ov_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic accept;

  assign rdy6 = !ov_r || out_if.ready;
  assign rdy5 = !v5_r || rdy6;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_if.ready = rdy1 && (state_r == btlbs_pkg::ST_RUN);
  assign accept      = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= accept;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) ov_r <= v5_r;
    end
  end

  // stage 0: decode, table writes and lookups
  logic [btlbs_pkg::FIELD_W-1:0]  atom_in [btlbs_pkg::LANES];
  btlbs_pkg::stage_t              st1_nxt, st1_r;
  logic [3:0]                     nat;
  logic [7:0]                     en_wide;
  logic                           query_en;
  logic                           atom_we;
  logic [btlbs_pkg::ATOM_AW-1:0]  atom_waddr;
  btlbs_pkg::blk_t                atom_wdata;
  btlbs_pkg::blk_t                blk_raw [btlbs_pkg::LANES];

  assign atom_in[0] = in_if.atom_a;
  assign atom_in[1] = in_if.atom_b;
  assign atom_in[2] = in_if.atom_c;
  assign atom_in[3] = in_if.atom_d;
  assign atom_in[4] = in_if.atom_e;
  assign atom_in[5] = in_if.atom_f;
  assign atom_in[6] = in_if.atom_g;
  assign atom_in[7] = in_if.atom_h;

  assign nat      = btlbs_pkg::atoms_of(in_if.term_type);
  assign en_wide  = 8'(term_enable_r);
  assign query_en = (btlbs_pkg::mode_t'(in_if.mode) == btlbs_pkg::MODE_QUERY)
                    && (in_if.term_type < 3'(btlbs_pkg::TYPES))
                    && en_wide[in_if.term_type];

  always_comb begin
    st1_nxt       = '0;
    st1_nxt.mode  = btlbs_pkg::mode_t'(in_if.mode);
    st1_nxt.cmap  = (in_if.term_type == btlbs_pkg::TERM_CMAP);
    st1_nxt.waddr = in_if.write_address;
    st1_nxt.wval  = in_if.write_value;
    for (int j = 0; j < btlbs_pkg::LANES; j++) begin
      st1_nxt.lane_en[j] = query_en && (4'(j) < nat)
                           && ({1'b0, atom_in[j]} < btlbs_pkg::ATOM_LIM);
    end
  end

  // clear sweep takes the write port until it ends
  always_comb begin
    if (state_r == btlbs_pkg::ST_CLEAR) begin
      atom_we    = 1'b1;
      atom_waddr = clr_addr_r;
      atom_wdata = '0;
    end else begin
      atom_we    = accept
                   && (btlbs_pkg::mode_t'(in_if.mode) == btlbs_pkg::MODE_WR_ATOM)
                   && ({1'b0, in_if.write_address} < btlbs_pkg::ATOM_LIM)
                   && ({1'b0, in_if.write_value} < btlbs_pkg::BLK_LIM);
      atom_waddr = in_if.write_address[btlbs_pkg::ATOM_AW-1:0];
      atom_wdata = in_if.write_value[btlbs_pkg::BLK_W-1:0];
    end
  end

  for (genvar g = 0; g < btlbs_pkg::LANES; g++) begin : g_atom_tab
    btlbs_ram #(
      .WIDTH (btlbs_pkg::BLK_W),
      .DEPTH (btlbs_pkg::MAX_ATOMS)
    ) u_atom_tab (
      .clk   (clk),
      .we    (atom_we),
      .waddr (atom_waddr),
      .wdata (atom_wdata),
      .re    (rdy1),
      .raddr (atom_in[g][btlbs_pkg::ATOM_AW-1:0]),
      .rdata (blk_raw[g])
    );
  end

  // stage 1: drop unused or out-of-range blocks, take the highest
  btlbs_pkg::stage_t st2_nxt, st2_r;

  always_comb begin
    st2_nxt = st1_r;
    for (int j = 0; j < btlbs_pkg::LANES; j++) begin
      st2_nxt.blk[j] = (st1_r.lane_en[j] && ({1'b0, blk_raw[j]} < block_count_r))
                       ? blk_raw[j] : '0;
    end
    st2_nxt.m1 = btlbs_pkg::max_below(st2_nxt.blk, btlbs_pkg::BLK_CNT_LIM);
  end

  // stages 2 and 3: next distinct blocks below the previous
  btlbs_pkg::stage_t st3_nxt, st3_r, st4_nxt, st4_r;

  always_comb begin
    st3_nxt    = st2_r;
    st3_nxt.m2 = btlbs_pkg::max_below(st2_r.blk, {1'b0, st2_r.m1});
    st4_nxt    = st3_r;
    st4_nxt.m3 = btlbs_pkg::max_below(st3_r.blk, {1'b0, st3_r.m2});
  end

  // stage 4: overflow block, site writes and site lookups
  btlbs_pkg::stage_t                 st5_nxt, st5_r;
  logic [btlbs_pkg::MAX_BLOCKS-1:0]  site_vld_r;
  logic                              site_we;
  btlbs_pkg::blk_t                   slot_addr [btlbs_pkg::SLOTS];
  logic [btlbs_pkg::SITE_W-1:0]      site_rd [btlbs_pkg::SLOTS];
  logic [btlbs_pkg::SLOTS-1:0]       site_ok_r;

  always_comb begin
    st5_nxt       = st4_r;
    st5_nxt.extra = st4_r.cmap
                    ? (btlbs_pkg::max_below(st4_r.blk, {1'b0, st4_r.m3}) != '0)
                    : (st4_r.m3 != '0);
  end

  assign site_we = v4_r && rdy5 && (st4_r.mode == btlbs_pkg::MODE_WR_SITE)
                   && ({1'b0, st4_r.waddr} < btlbs_pkg::BLK_LIM);

  assign slot_addr[0] = st4_r.m1;
  assign slot_addr[1] = st4_r.m2;
  assign slot_addr[2] = st4_r.m3;

  for (genvar s = 0; s < btlbs_pkg::SLOTS; s++) begin : g_site_tab
    btlbs_ram #(
      .WIDTH (btlbs_pkg::SITE_W),
      .DEPTH (btlbs_pkg::MAX_BLOCKS)
    ) u_site_tab (
      .clk   (clk),
      .we    (site_we),
      .waddr (st4_r.waddr[btlbs_pkg::BLK_W-1:0]),
      .wdata (st4_r.wval[btlbs_pkg::SITE_W-1:0]),
      .re    (rdy5),
      .raddr (slot_addr[s]),
      .rdata (site_rd[s])
    );
  end

  // an entry never written reads as site zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      site_vld_r <= '0;
    end else if (site_we) begin
      site_vld_r[st4_r.waddr[btlbs_pkg::BLK_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      for (int s = 0; s < btlbs_pkg::SLOTS; s++) begin
        site_ok_r[s] <= site_vld_r[slot_addr[s]];
      end
    end
  end

  // stage 5: site clash and overflow checks, pack
  logic [btlbs_pkg::SITE_W-1:0]  site [btlbs_pkg::SLOTS];
  btlbs_pkg::blk_t               slot [btlbs_pkg::SLOTS];
  logic                          clash;
  btlbs_pkg::status_t            stat;
  logic [btlbs_pkg::PACK_W-1:0]  pack [btlbs_pkg::SLOTS];
  logic [btlbs_pkg::PACK_W-1:0]  pf_nxt, ps_nxt, pt_nxt, pf_r, ps_r, pt_r;
  btlbs_pkg::status_t            stat_nxt, stat_r;

  assign slot[0] = st5_r.m1;
  assign slot[1] = st5_r.m2;
  assign slot[2] = st5_r.m3;

  always_comb begin
    for (int s = 0; s < btlbs_pkg::SLOTS; s++) begin
      site[s] = site_ok_r[s] ? site_rd[s] : '0;
      pack[s] = {site[s], {(btlbs_pkg::SITE_SHIFT - btlbs_pkg::BLK_W){1'b0}}, slot[s]};
    end
    clash = (slot[0] != '0 && slot[1] != '0 && slot[0] != slot[1] && site[0] == site[1]);
    if (st5_r.cmap) begin
      clash = clash
              || (slot[0] != '0 && slot[2] != '0 && slot[0] != slot[2] && site[0] == site[2])
              || (slot[1] != '0 && slot[2] != '0 && slot[1] != slot[2] && site[1] == site[2]);
    end
    if (clash) begin
      stat = btlbs_pkg::STAT_SITE_CLASH;
    end else if (st5_r.extra) begin
      stat = btlbs_pkg::STAT_TOO_MANY;
    end else begin
      stat = btlbs_pkg::STAT_OK;
    end

    pf_nxt   = '0;
    ps_nxt   = '0;
    pt_nxt   = '0;
    stat_nxt = btlbs_pkg::STAT_OK;
    if (st5_r.mode == btlbs_pkg::MODE_QUERY) begin
      stat_nxt = stat;
      if (stat == btlbs_pkg::STAT_OK) begin
        pf_nxt = pack[0];
        ps_nxt = pack[1];
        pt_nxt = st5_r.cmap ? pack[2] : '0;
      end
    end
  end

  // payload registers: advance where the next stage has room
  always_ff @(posedge clk) begin
    if (rdy1) st1_r <= st1_nxt;
    if (rdy2) st2_r <= st2_nxt;
    if (rdy3) st3_r <= st3_nxt;
    if (rdy4) st4_r <= st4_nxt;
    if (rdy5) st5_r <= st5_nxt;
    if (rdy6) begin
      pf_r   <= pf_nxt;
      ps_r   <= ps_nxt;
      pt_r   <= pt_nxt;
      stat_r <= stat_nxt;
    end
  end

  assign out_if.valid         = ov_r;
  assign out_if.packed_first  = pf_r;
  assign out_if.packed_second = ps_r;
  assign out_if.packed_third  = pt_r;
  assign out_if.status        = stat_r;

  a_clear_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == btlbs_pkg::ST_CLEAR |-> !in_if.ready)
    else $error("input taken during table clear");

  a_error_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && (stat_r != btlbs_pkg::STAT_OK) |->
      (pf_r == '0) && (ps_r == '0) && (pt_r == '0))
    else $error("error result carries nonzero slots");

  a_transfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> v1_r)
    else $error("accepted item missing from first stage");

  a_clear_owns_port: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == btlbs_pkg::ST_CLEAR |-> atom_we && (atom_wdata == '0))
    else $error("clear sweep lost the atom table write port");

endmodule
